// ===== rtl/blise_pkg.sv =====
`default_nettype none

package blise_pkg;

    // store capacity
    localparam int DEPTH = 64;

    // field widths fixed by the request and result formats
    localparam int DATA_W = 32;
    localparam int IDX_W  = 7;
    localparam int REQ_W  = 3;
    localparam int ST_W   = 2;

    // count holds 0 .. DEPTH
    localparam int CNT_W = $clog2(DEPTH + 1);
    // common width for index / count compares
    localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    // request codes
    localparam logic [REQ_W-1:0] REQ_INIT   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_APPEND = 3'd1;
    localparam logic [REQ_W-1:0] REQ_ERASE  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_GET    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SET    = 3'd4;

    // status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

    // per-cell control
    typedef struct packed {
        logic load;   // take the broadcast word
        logic shift;  // take the upper neighbor's word
        logic sel;    // this cell is addressed by the request index
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/blise_cell.sv =====
`default_nettype none

module blise_cell
    import blise_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cell_ctrl_t        ctrl,
    input  wire logic [DATA_W-1:0] load_data,
    input  wire logic [DATA_W-1:0] upper_data,
    output logic      [DATA_W-1:0] data,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.load)
        begin
            data_next = load_data;
        end
        else if (ctrl.shift)
        begin
            data_next = upper_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign data    = data_reg;
    // gated so the row can be or-reduced
    assign rd_data = ctrl.sel ? data_reg : '0;

endmodule

`default_nettype wire

// ===== rtl/bounded_int_list_shift_erase_unit.sv =====
`default_nettype none

// bounded list of signed 32-bit words with a current length
//
// input channel s_axis: one request per beat
//   s_axis_tuser carries the request kind (init, append, erase, get, set)
//   s_axis_tdata carries the index (or new length for init) and the word
// output channel m_axis: exactly one result beat per request, in order
//   m_axis_tdata carries the read word and the length after the request
//   m_axis_tuser carries the status (ok, store full, index out of range)
//
// the entries sit in a row of cells, one word each; every cell can load the
// broadcast word or copy its upper neighbor, so init fills all cells, append,
// set load one cell, and erase shifts the tail down by one
// get reads through a gated or-reduction across the row
// the result beat is registered and appears in the cycle after its request is accepted
// throughput: one request per cycle; the only storage on the path is the
// single result register, so a request is taken whenever that register is
// empty or being drained in the same cycle
// receiver stall: the result holds in the output register and s_axis_tready
// drops until it is taken; no state changes while stalled
// reset: all entries zero, length zero, no result pending

module bounded_int_list_shift_erase_unit
    import blise_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [6:0] index, [38:7] value, [39] zero
    input  wire logic [39:0] s_axis_tdata,
    // [2:0] req_type
    input  wire logic [2:0]  s_axis_tuser,

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [31:0] read_data, [38:32] length, [39] zero
    output logic      [39:0] m_axis_tdata,
    // [1:0] status
    output logic      [1:0]  m_axis_tuser
);

    // request fields
    logic [REQ_W-1:0]  req_type;
    logic [IDX_W-1:0]  req_index;
    logic [DATA_W-1:0] req_value;

    assign req_type  = s_axis_tuser;
    assign req_index = s_axis_tdata[IDX_W-1:0];
    assign req_value = s_axis_tdata[IDX_W+DATA_W-1:IDX_W];

    // length
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // result register
    logic              out_valid_reg;
    logic [DATA_W-1:0] rd_reg;
    logic [DATA_W-1:0] rd_next;
    logic [IDX_W-1:0]  len_reg;
    logic [IDX_W-1:0]  len_next;
    logic [ST_W-1:0]   st_reg;
    logic [ST_W-1:0]   st_next;

    logic s_fire;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // compares at a common width
    logic [CMP_W-1:0] idx_ext;
    logic [CMP_W-1:0] cnt_ext;
    assign idx_ext = CMP_W'(req_index);
    assign cnt_ext = CMP_W'(count_reg);

    logic idx_in_list;
    logic init_ok;
    logic append_ok;
    assign idx_in_list = idx_ext < cnt_ext;
    assign init_ok     = idx_ext <= CMP_W'(DEPTH);
    assign append_ok   = cnt_ext < CMP_W'(DEPTH);

    logic do_init;
    logic do_append;
    logic do_erase;
    logic do_get;
    logic do_set;
    assign do_init   = s_fire && (req_type == REQ_INIT)   && init_ok;
    assign do_append = s_fire && (req_type == REQ_APPEND) && append_ok;
    assign do_erase  = s_fire && (req_type == REQ_ERASE)  && idx_in_list;
    assign do_get    = (req_type == REQ_GET) && idx_in_list;
    assign do_set    = s_fire && (req_type == REQ_SET)    && idx_in_list;

    // row of cells
    cell_ctrl_t        cell_ctrl [DEPTH];
    logic [DATA_W-1:0] cell_data [DEPTH];
    logic [DATA_W-1:0] cell_rd   [DEPTH];
    logic [DEPTH-1:0]  load_vec;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam logic [CMP_W-1:0] POS = CMP_W'(i);

        logic [DATA_W-1:0] upper;

        // top cell has no upper neighbor; its shift never fires
        if (i == DEPTH - 1)
        begin : g_top
            assign upper = cell_data[i];
        end
        else
        begin : g_mid
            assign upper = cell_data[i+1];
        end

        always_comb
        begin
            cell_ctrl[i].sel   = (idx_ext == POS);
            cell_ctrl[i].load  = do_init
                              || (do_append && (cnt_ext == POS))
                              || (do_set && (idx_ext == POS));
            // entries idx .. count-2 take their upper neighbor
            cell_ctrl[i].shift = do_erase && (POS >= idx_ext) && ((POS + 1'b1) < cnt_ext);
        end

        assign load_vec[i] = cell_ctrl[i].load;

        blise_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (cell_ctrl[i]),
            .load_data  (req_value),
            .upper_data (upper),
            .data       (cell_data[i]),
            .rd_data    (cell_rd[i])
        );
    end

    // or-reduce the gated row for get
    logic [DATA_W-1:0] row_rd;
    always_comb
    begin
        row_rd = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            row_rd = row_rd | cell_rd[i];
        end
    end

    // next length, status and read word
    always_comb
    begin
        count_next = count_reg;
        st_next    = ST_OK;
        rd_next    = '0;
        case (req_type)
            REQ_INIT:
            begin
                if (init_ok)
                begin
                    count_next = CNT_W'(idx_ext);
                end
                else
                begin
                    st_next = ST_RANGE;
                end
            end
            REQ_APPEND:
            begin
                if (append_ok)
                begin
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    st_next = ST_FULL;
                end
            end
            REQ_ERASE:
            begin
                if (idx_in_list)
                begin
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    st_next = ST_RANGE;
                end
            end
            REQ_GET:
            begin
                if (do_get)
                begin
                    rd_next = row_rd;
                end
                else
                begin
                    st_next = ST_RANGE;
                end
            end
            REQ_SET:
            begin
                if (!idx_in_list)
                begin
                    st_next = ST_RANGE;
                end
            end
            default:
            begin
                // unknown kinds leave the length and entries alone and report ok
                st_next = ST_OK;
            end
        endcase
    end

    logic [CMP_W-1:0] cnt_next_ext;
    assign cnt_next_ext = CMP_W'(count_next);
    assign len_next     = cnt_next_ext[IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_fire)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            rd_reg  <= rd_next;
            len_reg <= len_next;
            st_reg  <= st_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, len_reg, rd_reg};
    assign m_axis_tuser  = st_reg;

    // length never passes capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(count_reg) <= CMP_W'(DEPTH))
        else $error("length beyond capacity");

    // outside init at most one cell takes the broadcast word
    a_single_load: assert property (@(posedge clk) disable iff (!rst_n)
        !do_init |-> $onehot0(load_vec))
        else $error("more than one cell loaded");

    // a good append grows the length by one
    a_append_grow: assert property (@(posedge clk) disable iff (!rst_n)
        do_append |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("append did not grow length");

    // every accepted request leaves a result pending
    a_result_pending: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> m_axis_tvalid)
        else $error("result missing after request");

    // erase and shift never act in the same cycle as a load
    a_shift_excl: assert property (@(posedge clk) disable iff (!rst_n)
        do_erase |-> (load_vec == '0))
        else $error("load during erase");

endmodule

`default_nettype wire
